// ----- rtl/clt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the cursor linked list table
// Table geometry, command and status codes, controller states and the
// command/status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int SLOTS    = 8;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int LINK_W   = IDX_W + 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  // A link of all ones marks the end of the list.
  localparam logic [LINK_W-1:0] LINK_END = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADINDEX = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_LINK_A,
    S_LINK_B,
    S_REM_READ,
    S_REM_SCAN,
    S_REM_FREE,
    S_FIND
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ZERO,
    CUR_POS,
    CUR_FOLLOW,
    CUR_STEP
  } cur_op_t;

  typedef enum logic [1:0] {
    LA_FRESH,
    LA_CUR,
    LA_POS
  } link_addr_t;

  typedef enum logic [1:0] {
    LD_RDLINK,
    LD_FRESH,
    LD_SAVED,
    LD_END
  } link_data_t;

  typedef enum logic [1:0] {
    SS_ZERO,
    SS_FRESH,
    SS_CUR,
    SS_POS
  } slot_sel_t;

  typedef struct packed {
    logic       load;
    cur_op_t    cur_op;
    logic       save_link;
    logic       link_we;
    link_addr_t link_addr;
    link_data_t link_data;
    logic       claim;
    logic       release_pos;
    logic       emit;
    status_t    res_status;
    slot_sel_t  res_slot;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic ins_bad;
    logic rem_bad;
    logic walk_stop;
    logic rem_hit;
    logic find_hit;
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/clt_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_dp: datapath of the cursor linked list table
// Holds the slot table, the captured command, the cursor and step counter,
// the free-slot encoder and the registered result.
// ----------------------------------------------------------------------------
module clt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [clt_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [clt_pkg::VALUE_W-1:0] in_value,
  input  logic [clt_pkg::POS_W-1:0]         in_position,
  input  clt_pkg::dp_ctrl_t                 ctrl,
  output clt_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  output logic [clt_pkg::STATUS_W-1:0]      out_status,
  output logic [clt_pkg::SLOT_W-1:0]        out_slot
);
  import clt_pkg::*;

  cmd_t                cmd_r;
  logic [VALUE_W-1:0]  val_r;
  logic [POS_W-1:0]    pos_r;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LINK_W-1:0]   saved_r;
  logic [VALUE_W-1:0]  value_r [SLOTS];
  logic [LINK_W-1:0]   next_r  [SLOTS];
  logic [SLOTS-1:0]    used_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic [IDX_W-1:0]    pos_idx;
  logic                pos_in_range;
  logic [LINK_W-1:0]   rd_link;
  logic                rd_used;
  logic [VALUE_W-1:0]  rd_value;
  logic [IDX_W-1:0]    link_idx;
  logic                link_ok;
  logic [IDX_W-1:0]    fresh;
  logic                full;
  logic [IDX_W-1:0]    wr_addr;
  logic [LINK_W-1:0]   wr_data;
  logic [IDX_W-1:0]    res_idx;

  assign pos_idx      = IDX_W'(pos_r);
  assign pos_in_range = 32'(pos_r) < SLOTS;

  // The link, used and value reads go through the cursor.
  assign rd_link  = next_r[cur_r];
  assign rd_used  = used_r[cur_r];
  assign rd_value = value_r[cur_r];
  assign link_idx = rd_link[IDX_W-1:0];
  assign link_ok  = (32'(rd_link) < SLOTS) && used_r[link_idx];

  // Lowest free slot from 1 upward.
  always_comb begin
    fresh = '0;
    full  = 1'b1;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (!used_r[i]) begin
        fresh = IDX_W'(i);
        full  = 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.full      = full;
    stat.ins_bad   = !pos_in_range || !used_r[pos_idx];
    stat.rem_bad   = !pos_in_range || !used_r[pos_idx] || (pos_r == '0);
    stat.walk_stop = !link_ok || (cnt_r == CNT_W'(SLOTS));
    stat.rem_hit   = rd_used && (rd_link == {1'b0, pos_idx});
    stat.find_hit  = (cur_r != '0) && rd_used && (rd_value == val_r);
    stat.scan_last = cur_r == IDX_W'(SLOTS - 1);
  end

  always_comb begin
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    case (ctrl.cur_op)
      CUR_HOLD: begin
        cur_nxt = cur_r;
      end
      CUR_ZERO: begin
        cur_nxt = '0;
        cnt_nxt = '0;
      end
      CUR_POS: begin
        cur_nxt = pos_idx;
      end
      CUR_FOLLOW: begin
        cur_nxt = link_idx;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      CUR_STEP: begin
        cur_nxt = cur_r + IDX_W'(1);
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_comb begin
    case (ctrl.link_addr)
      LA_FRESH: wr_addr = fresh;
      LA_CUR:   wr_addr = cur_r;
      LA_POS:   wr_addr = pos_idx;
      default:  wr_addr = cur_r;
    endcase
    case (ctrl.link_data)
      LD_RDLINK: wr_data = rd_link;
      LD_FRESH:  wr_data = {1'b0, fresh};
      LD_SAVED:  wr_data = saved_r;
      LD_END:    wr_data = LINK_END;
      default:   wr_data = LINK_END;
    endcase
    case (ctrl.res_slot)
      SS_ZERO:  res_idx = '0;
      SS_FRESH: res_idx = fresh;
      SS_CUR:   res_idx = cur_r;
      SS_POS:   res_idx = pos_idx;
      default:  res_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= cmd_t'(in_cmd);
      val_r <= in_value;
      pos_r <= in_position;
    end
    cur_r <= cur_nxt;
    cnt_r <= cnt_nxt;
    if (ctrl.save_link) begin
      saved_r <= rd_link;
    end
    if (ctrl.claim) begin
      value_r[fresh] <= val_r;
    end
    if (ctrl.emit) begin
      out_status_r <= ctrl.res_status;
      out_slot_r   <= SLOT_W'(res_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        next_r[i] <= LINK_END;
      end
      used_r      <= SLOTS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.link_we) begin
        next_r[wr_addr] <= wr_data;
      end
      if (ctrl.claim) begin
        used_r[fresh] <= 1'b1;
      end
      if (ctrl.release_pos) begin
        used_r[pos_idx] <= 1'b0;
      end
      out_valid_r <= ctrl.emit;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule
`default_nettype wire

// ----- rtl/clt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_ctrl: controller of the cursor linked list table
// Sequences each command over the datapath: tail walk, link, predecessor
// scan, free and value scan, and issues the single result.
// ----------------------------------------------------------------------------
module clt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  clt_pkg::dp_stat_t stat,
  output clt_pkg::dp_ctrl_t ctrl
);
  import clt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt        = state_r;
    ctrl             = '0;
    ctrl.cur_op      = CUR_HOLD;
    ctrl.link_addr   = LA_CUR;
    ctrl.link_data   = LD_END;
    ctrl.res_status  = ST_OK;
    ctrl.res_slot    = SS_ZERO;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load   = 1'b1;
          ctrl.cur_op = CUR_ZERO;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_APPEND: begin
            if (stat.full) begin
              ctrl.emit       = 1'b1;
              ctrl.res_status = ST_NOSPACE;
              state_nxt       = S_IDLE;
            end else begin
              state_nxt = S_WALK;
            end
          end
          CMD_INSERT: begin
            if (stat.ins_bad) begin
              ctrl.emit       = 1'b1;
              ctrl.res_status = ST_BADINDEX;
              state_nxt       = S_IDLE;
            end else if (stat.full) begin
              ctrl.emit       = 1'b1;
              ctrl.res_status = ST_NOSPACE;
              state_nxt       = S_IDLE;
            end else begin
              ctrl.cur_op = CUR_POS;
              state_nxt   = S_LINK_A;
            end
          end
          CMD_REMOVE: begin
            if (stat.rem_bad) begin
              ctrl.emit       = 1'b1;
              ctrl.res_status = ST_BADINDEX;
              state_nxt       = S_IDLE;
            end else begin
              ctrl.cur_op = CUR_POS;
              state_nxt   = S_REM_READ;
            end
          end
          CMD_FIND: begin
            state_nxt = S_FIND;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        // Follow links from the head until the chain ends.
        if (stat.walk_stop) begin
          state_nxt = S_LINK_A;
        end else begin
          ctrl.cur_op = CUR_FOLLOW;
        end
      end
      S_LINK_A: begin
        // The new slot inherits the successor of the cursor slot.
        ctrl.link_we   = 1'b1;
        ctrl.link_addr = LA_FRESH;
        ctrl.link_data = LD_RDLINK;
        state_nxt      = S_LINK_B;
      end
      S_LINK_B: begin
        ctrl.link_we   = 1'b1;
        ctrl.link_addr = LA_CUR;
        ctrl.link_data = LD_FRESH;
        ctrl.claim     = 1'b1;
        ctrl.emit      = 1'b1;
        ctrl.res_slot  = SS_FRESH;
        state_nxt      = S_IDLE;
      end
      S_REM_READ: begin
        ctrl.save_link = 1'b1;
        ctrl.cur_op    = CUR_ZERO;
        state_nxt      = S_REM_SCAN;
      end
      S_REM_SCAN: begin
        if (stat.rem_hit) begin
          ctrl.link_we   = 1'b1;
          ctrl.link_addr = LA_CUR;
          ctrl.link_data = LD_SAVED;
          state_nxt      = S_REM_FREE;
        end else if (stat.scan_last) begin
          ctrl.emit       = 1'b1;
          ctrl.res_status = ST_BADINDEX;
          state_nxt       = S_IDLE;
        end else begin
          ctrl.cur_op = CUR_STEP;
        end
      end
      S_REM_FREE: begin
        ctrl.link_we     = 1'b1;
        ctrl.link_addr   = LA_POS;
        ctrl.link_data   = LD_END;
        ctrl.release_pos = 1'b1;
        ctrl.emit        = 1'b1;
        ctrl.res_slot    = SS_POS;
        state_nxt        = S_IDLE;
      end
      S_FIND: begin
        if (stat.find_hit) begin
          ctrl.emit     = 1'b1;
          ctrl.res_slot = SS_CUR;
          state_nxt     = S_IDLE;
        end else if (stat.scan_last) begin
          ctrl.emit       = 1'b1;
          ctrl.res_status = ST_NOTFOUND;
          state_nxt       = S_IDLE;
        end else begin
          ctrl.cur_op = CUR_STEP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/cursor_linked_list_table_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_linked_list_table_top: linked list kept in a fixed table of slots
// A command rejected at decode issues its result from the decode state. Append walks the chain
// to the tail, find scans the slots and remove scans for the predecessor, one entry per cycle
// through a single cursor. One command at a time: busy is high until the result is issued,
// and the next start is taken in the strobe cycle. Results cannot be stalled. Synchronous
// reset leaves only the head used.
// ----------------------------------------------------------------------------
module cursor_linked_list_table_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [clt_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [clt_pkg::VALUE_W-1:0] in_value,
  input  logic [clt_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  output logic [clt_pkg::STATUS_W-1:0]       out_status,
  output logic [clt_pkg::SLOT_W-1:0]         out_slot
);
  import clt_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  clt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  clt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .in_position (in_position),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot)
  );

endmodule
`default_nettype wire

// ----- sim/list_table_checker.sv -----
// ----------------------------------------------------------------------------
// list_table_checker: result predictor and scoreboard for the linked list table
// Watches the command and result channels of the block, keeps its own copy of
// the slot table, works out the status and slot of every accepted command and
// compares each result strobe with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module list_table_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [clt_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [clt_pkg::VALUE_W-1:0] in_value,
  input  logic [clt_pkg::POS_W-1:0]          in_position,
  input  logic                               out_valid,
  input  logic [clt_pkg::STATUS_W-1:0]       out_status,
  input  logic [clt_pkg::SLOT_W-1:0]         out_slot,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import clt_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } list_result_t;

  logic [VALUE_W-1:0] slot_value [SLOTS];
  logic [LINK_W-1:0]  slot_link  [SLOTS];
  logic               slot_used  [SLOTS];

  list_result_t expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int lowest_free_slot();
    for (int i = 1; i < SLOTS; i++) begin
      if (!slot_used[i]) return i;
    end
    return 0;
  endfunction

  function automatic void link_in(int prev, int fresh, logic [VALUE_W-1:0] val);
    slot_link[fresh]  = slot_link[prev];
    slot_link[prev]   = LINK_W'(fresh);
    slot_value[fresh] = val;
    slot_used[fresh]  = 1'b1;
  endfunction

  // Applies one command to the shadow table and returns the result it must give.
  function automatic list_result_t apply_command(cmd_t op, logic [VALUE_W-1:0] val,
                                                 logic [POS_W-1:0] pos);
    list_result_t res;
    int           fresh;
    int           cur;
    int           nxt;
    res.status = ST_OK;
    res.slot   = '0;
    case (op)
      CMD_APPEND: begin
        fresh = lowest_free_slot();
        if (fresh == 0) begin
          res.status = ST_NOSPACE;
        end else begin
          // Walk from the head; a link to a free slot ends the list as well.
          cur = 0;
          for (int n = 0; n < SLOTS; n++) begin
            nxt = slot_link[cur];
            if (nxt >= SLOTS || !slot_used[nxt]) break;
            cur = nxt;
          end
          link_in(cur, fresh, val);
          res.slot = fresh[SLOT_W-1:0];
        end
      end
      CMD_INSERT: begin
        if (pos >= SLOTS || !slot_used[pos]) begin
          res.status = ST_BADINDEX;
        end else begin
          fresh = lowest_free_slot();
          if (fresh == 0) begin
            res.status = ST_NOSPACE;
          end else begin
            link_in(pos, fresh, val);
            res.slot = fresh[SLOT_W-1:0];
          end
        end
      end
      CMD_REMOVE: begin
        res.status = ST_BADINDEX;
        if (pos != 0 && pos < SLOTS && slot_used[pos]) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_link[i] == LINK_W'(pos)) begin
              slot_link[i]   = slot_link[pos];
              slot_link[pos] = LINK_END;
              slot_used[pos] = 1'b0;
              res.status     = ST_OK;
              res.slot       = pos[SLOT_W-1:0];
              break;
            end
          end
        end
      end
      default: begin
        res.status = ST_NOTFOUND;
        for (int i = 1; i < SLOTS; i++) begin
          if (slot_used[i] && slot_value[i] == val) begin
            res.status = ST_OK;
            res.slot   = i[SLOT_W-1:0];
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_value[i] = '0;
        slot_link[i]  = LINK_END;
        slot_used[i]  = (i == 0);
      end
      expected_results.delete();
    end else begin
      // The block may take the next command in the strobe cycle, so the
      // result is checked before the new transaction is predicted.
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("out_valid with no transaction pending: status %0d, slot %0d",
                 out_status, out_slot);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_slot !== want.slot) begin
            $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_command(cmd_t'(in_cmd), in_value, in_position));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/tb_cursor_linked_list_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_table_top: stimulus and verdict for the list table
// Drives a directed command sequence through empty, full and error cases,
// then bursts of random append, insert, remove and find commands that swing
// the table between empty and full. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import clt_pkg::*;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [CMD_W-1:0]          in_cmd;
  logic signed [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]          in_position;
  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic [SLOT_W-1:0]         out_slot;
  int                        fail_count;
  int                        pending;
  int                        quiet_cycles;

  // Values written lately, so that finds often hit.
  logic [VALUE_W-1:0] recent_values [16];
  int                 recent_wr;

  cursor_linked_list_table_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot)
  );

  list_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one command and returns at the edge that accepts it; start stays
  // high so that a following call makes a back-to-back transaction.
  task automatic issue(cmd_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    @(negedge clk);
    start       = 1'b1;
    in_cmd      = op;
    in_value    = val;
    in_position = pos;
    if (op == CMD_APPEND || op == CMD_INSERT) begin
      recent_values[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 16;
    end
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    pause(0);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_store_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return VALUE_W'($urandom_range(0, 3));
    if (roll == 4) begin
      case ($urandom_range(0, 2))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    int   sent;
    int   burst;
    int   roll;
    bit   growing;
    cmd_t op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0]   pos;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = CMD_FIND;
    in_value    = '0;
    in_position = '0;
    recent_wr   = 0;
    for (int i = 0; i < 16; i++) recent_values[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: errors on the empty table, front insertion, extreme and
    // zero values, a full table, and removal of middle, tail and first slots.
    issue(CMD_FIND,   32'd0,         4'd0);
    issue(CMD_REMOVE, 32'd0,         4'd0);
    issue(CMD_REMOVE, 32'd0,         4'd15);
    issue(CMD_INSERT, 32'd1,         4'd3);
    issue(CMD_INSERT, 32'd1,         4'd9);
    issue(CMD_APPEND, 32'd0,         4'd0);
    issue(CMD_APPEND, 32'h8000_0000, 4'd0);
    issue(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
    issue(CMD_APPEND, 32'h7FFF_FFFF, 4'd0);
    issue(CMD_FIND,   32'd0,         4'd0);
    issue(CMD_FIND,   32'hFFFF_FFFF, 4'd0);
    issue(CMD_FIND,   32'h7FFF_FFFF, 4'd0);
    issue(CMD_REMOVE, 32'd0,         4'd1);
    issue(CMD_FIND,   32'd0,         4'd0);
    issue(CMD_APPEND, 32'd5,         4'd0);
    issue(CMD_INSERT, 32'd5,         4'd2);
    issue(CMD_APPEND, 32'd6,         4'd0);
    issue(CMD_APPEND, 32'd7,         4'd0);
    issue(CMD_APPEND, 32'd8,         4'd0);
    issue(CMD_INSERT, 32'd9,         4'd0);
    issue(CMD_INSERT, 32'd9,         4'd12);
    issue(CMD_FIND,   32'd5,         4'd0);
    issue(CMD_REMOVE, 32'd0,         4'd7);
    issue(CMD_REMOVE, 32'd0,         4'd7);
    issue(CMD_REMOVE, 32'd0,         4'd3);
    wait_drained();

    // Random part: the mix leans toward filling or toward emptying the table
    // and flips now and then, so both the full and the empty cases recur.
    sent    = 0;
    growing = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 39) == 0) growing = !growing;
        roll = $urandom_range(0, 99);
        if (growing) begin
          op = (roll < 40) ? CMD_APPEND : (roll < 65) ? CMD_INSERT :
               (roll < 80) ? CMD_REMOVE : CMD_FIND;
        end else begin
          op = (roll < 10) ? CMD_APPEND : (roll < 20) ? CMD_INSERT :
               (roll < 75) ? CMD_REMOVE : CMD_FIND;
        end
        roll = $urandom_range(0, 19);
        case (op)
          CMD_REMOVE: pos = (roll == 0) ? 4'd0 :
                            (roll < 3) ? POS_W'($urandom_range(8, 15)) :
                            POS_W'($urandom_range(1, 7));
          CMD_INSERT: pos = (roll < 4) ? POS_W'($urandom_range(8, 15)) :
                            POS_W'($urandom_range(0, 7));
          default:    pos = POS_W'($urandom);
        endcase
        if (op == CMD_FIND) begin
          roll = $urandom_range(0, 9);
          val = (roll < 6) ? recent_values[$urandom_range(0, 15)] :
                (roll < 8) ? VALUE_W'($urandom_range(0, 3)) : VALUE_W'($urandom);
        end else begin
          val = pick_store_value();
        end
        issue(op, val, pos);
        sent++;
        if (sent % 325 == 0) wait_drained();
      end
      roll = $urandom_range(0, 9);
      if (roll < 3) begin
        pause(($urandom_range(0, 7) == 0) ? 30 : $urandom_range(0, 12));
      end else if (roll < 7) begin
        pause($urandom_range(0, 4));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/clt_pkg.sv
rtl/clt_dp.sv
rtl/clt_ctrl.sv
rtl/cursor_linked_list_table_top.sv
sim/list_table_checker.sv
sim/tb_cursor_linked_list_table_top.sv
